// ===== design/ppd_pkg.sv =====
// Shared types and constants for the pulse peak detector.
// No dependencies; every other design file refers to this package by scoped names.

package ppd_pkg;

  // Width of the wrapping sample counter and of the stored index values.
  localparam int INDEX_BITS = 32;

  localparam int SAMPLE_BITS = 16;
  localparam int AMP_BITS    = 16;
  localparam int CFG_BITS    = 16;
  localparam int OUT_INDEX_BITS = 32;
  localparam int COUNT_BITS  = 32;

  // Configuration register indexes.
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_HOLDOFF   = 1'b1;

  localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 16'd1000;
  localparam logic [CFG_BITS-1:0] HOLDOFF_RESET   = 16'd4;

  // Pulse tracking states.
  typedef enum logic [2:0] {
    PH_NOISE   = 3'b001,
    PH_PEAK    = 3'b010,
    PH_LEAVING = 3'b100
  } phase_t;

  // One finished pulse as produced by the tracker.
  typedef struct packed {
    logic                      valid;
    logic [OUT_INDEX_BITS-1:0] peak_index;
    logic [AMP_BITS-1:0]       peak_amplitude;
    logic [COUNT_BITS-1:0]     pulse_count;
  } ppd_result_t;

endpackage

// ===== design/ppd_sample_if.sv =====
// Stream interface that carries one signed sample word per handshake.
// Depends on ppd_pkg for the sample width.

interface ppd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ppd_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/ppd_peak_if.sv =====
// Stream interface that carries one finished-pulse word per handshake.
// Depends on ppd_pkg for the field widths.

interface ppd_peak_if;
  logic                                valid;
  logic                                ready;
  logic [ppd_pkg::OUT_INDEX_BITS-1:0]  peak_index;
  logic [ppd_pkg::AMP_BITS-1:0]        peak_amplitude;
  logic [ppd_pkg::COUNT_BITS-1:0]      pulse_count;

  modport source (output valid, output peak_index, output peak_amplitude,
                  output pulse_count, input ready);
  modport sink   (input valid, input peak_index, input peak_amplitude,
                  input pulse_count, output ready);
endinterface

// ===== design/ppd_tracker.sv =====
// Pulse state machine: holds phase, sample index, current peak and pulse count.
// Depends on ppd_pkg for the state encoding and the result struct.

module ppd_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [ppd_pkg::AMP_BITS-1:0]  mag,
  input  logic [ppd_pkg::CFG_BITS-1:0]  threshold,
  input  logic [ppd_pkg::CFG_BITS-1:0]  holdoff,
  output ppd_pkg::ppd_result_t          result
);

  ppd_pkg::phase_t                     phase, phase_next;
  logic [ppd_pkg::INDEX_BITS-1:0]      sample_index, sample_index_next;
  logic [ppd_pkg::INDEX_BITS-1:0]      peak_position, peak_position_next;
  logic [ppd_pkg::AMP_BITS-1:0]        peak_value, peak_value_next;
  logic [ppd_pkg::INDEX_BITS-1:0]      below_since, below_since_next;
  logic [ppd_pkg::COUNT_BITS-1:0]      pulses_seen, pulses_seen_next;

  logic                                above;
  logic                                bigger;
  logic                                expired;
  logic                                emit;
  logic [ppd_pkg::INDEX_BITS-1:0]      elapsed;
  logic [63:0]                         position_wide;

  assign above   = mag >= threshold;
  assign bigger  = mag > peak_value;
  assign elapsed = sample_index - below_since;
  assign expired = elapsed > ppd_pkg::INDEX_BITS'(holdoff);

  always_comb begin
    phase_next         = phase;
    peak_position_next = peak_position;
    peak_value_next    = peak_value;
    below_since_next   = below_since;
    pulses_seen_next   = pulses_seen;
    emit               = 1'b0;
    case (phase)
      ppd_pkg::PH_LEAVING: begin
        if (!above) begin
          if (expired) begin
            emit             = 1'b1;
            pulses_seen_next = pulses_seen + 1'b1;
            phase_next       = ppd_pkg::PH_NOISE;
          end
        end else begin
          // Signal came back: the pulse continues and this sample may be a new peak.
          phase_next = ppd_pkg::PH_PEAK;
          if (bigger) begin
            peak_position_next = sample_index;
            peak_value_next    = mag;
          end
        end
      end
      ppd_pkg::PH_PEAK: begin
        if (above) begin
          if (bigger) begin
            peak_position_next = sample_index;
            peak_value_next    = mag;
          end
        end else begin
          below_since_next = sample_index;
          phase_next       = ppd_pkg::PH_LEAVING;
        end
      end
      default: begin
        if (above) begin
          peak_position_next = sample_index;
          peak_value_next    = mag;
          phase_next         = ppd_pkg::PH_PEAK;
        end
      end
    endcase
    sample_index_next = sample_index + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ppd_pkg::PH_NOISE;
      sample_index  <= '0;
      peak_position <= '0;
      peak_value    <= '0;
      below_since   <= '0;
      pulses_seen   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      sample_index  <= sample_index_next;
      peak_position <= peak_position_next;
      peak_value    <= peak_value_next;
      below_since   <= below_since_next;
      pulses_seen   <= pulses_seen_next;
    end
  end

  assign position_wide          = 64'(peak_position);
  assign result.valid          = emit;
  assign result.peak_index     = position_wide[ppd_pkg::OUT_INDEX_BITS-1:0];
  assign result.peak_amplitude = peak_value;
  assign result.pulse_count    = pulses_seen_next;

  // A pulse can only finish from the leaving state.
  a_emit_from_leaving: assert property (@(posedge clk) disable iff (rst)
    emit |-> phase == ppd_pkg::PH_LEAVING)
    else $error("pulse finished outside the leaving state");

  // A finished pulse returns the machine to noise and counts exactly once.
  a_emit_to_noise: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == ppd_pkg::PH_NOISE
                     && pulses_seen == $past(pulses_seen) + 1'b1)
    else $error("pulse end did not reset the phase or bump the count");

  // Without a finished pulse the count never moves.
  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    !(step && emit) |=> $stable(pulses_seen))
    else $error("pulse count changed without a finished pulse");

  // The sample index advances by one for every processed sample.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    step |=> sample_index == $past(sample_index) + 1'b1)
    else $error("sample index did not advance");

endmodule

// ===== design/pulse_peak_detector.sv =====
// Top level of the pulse peak detector: input register, magnitude, tracker, output register.
// Depends on ppd_pkg, ppd_sample_if, ppd_peak_if and ppd_tracker.
//
//   Port      Dir  Word contents                                  Handshake
//   samples   in   sample (signed 16)                             valid/ready
//   peaks     out  peak_index (32), peak_amplitude (16),          valid/ready
//                  pulse_count (32)
//   cfg_*     in   cfg_index selects threshold or holdoff,        cfg_we, no wait
//                  cfg_data is the 16-bit value
//
// One sample word is accepted per clock while the output side drains.
// An accepted sample waits in the input register until it moves into the
// tracker; a pulse it finishes goes to the output register and onto peaks.
// The input register and the output register each hold one word, so a
// stalled output blocks new samples only once both are full.
// rst is synchronous and active high; it restores threshold 1000, holdoff 4
// and clears the pulse state, the sample index and the pulse count.

module pulse_peak_detector (
  input  logic                          clk,
  input  logic                          rst,
  ppd_sample_if.sink                    samples,
  ppd_peak_if.source                    peaks,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ppd_pkg::CFG_BITS-1:0]  cfg_data
);

  // Configuration registers.
  logic [ppd_pkg::CFG_BITS-1:0] threshold;
  logic [ppd_pkg::CFG_BITS-1:0] holdoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ppd_pkg::THRESHOLD_RESET;
      holdoff   <= ppd_pkg::HOLDOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ppd_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        ppd_pkg::CFG_HOLDOFF:   holdoff   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. The held sample moves into the tracker when the output
  // register is empty or is being emptied in the same cycle.
  logic                                   in_valid;
  logic signed [ppd_pkg::SAMPLE_BITS-1:0] in_sample;
  logic                                   out_valid;
  logic                                   advance;

  assign advance       = in_valid && (!out_valid || peaks.ready);
  assign samples.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_sample <= samples.sample;
    end
  end

  // Absolute value; the most negative sample maps to 32768, which still fits.
  logic [ppd_pkg::SAMPLE_BITS:0] negated;
  logic [ppd_pkg::AMP_BITS-1:0]  mag;

  assign negated = '0 - {in_sample[ppd_pkg::SAMPLE_BITS-1], in_sample};
  assign mag     = in_sample[ppd_pkg::SAMPLE_BITS-1] ?
                   negated[ppd_pkg::AMP_BITS-1:0] : ppd_pkg::AMP_BITS'(in_sample);

  ppd_pkg::ppd_result_t result;

  ppd_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .mag       (mag),
    .threshold (threshold),
    .holdoff   (holdoff),
    .result    (result)
  );

  // Output register.
  ppd_pkg::ppd_result_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (peaks.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_word <= result;
    end
  end

  assign peaks.valid          = out_valid;
  assign peaks.peak_index     = out_word.peak_index;
  assign peaks.peak_amplitude = out_word.peak_amplitude;
  assign peaks.pulse_count    = out_word.pulse_count;

  // A held sample that cannot move on stays in the input register.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_sample))
    else $error("input sample dropped while the output was stalled");

  // A new result is never loaded over a word that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance && result.valid |-> !out_valid || peaks.ready)
    else $error("output word overwritten before it was taken");

  // A pending output word stays until it is taken.
  a_keep_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && !peaks.ready |=> out_valid && $stable(out_word))
    else $error("pending output word lost");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for pulse_peak_detector: drives sample words, predicts finished pulses.
// Depends on ppd_pkg, ppd_sample_if, ppd_peak_if and the pulse_peak_detector top level.

module testbench;

  // Cycles allowed to pass after the last expected word before the block is
  // treated as idle.
  localparam int SETTLE_CYCLES = 6;
  // Longest stretch of cycles with no word moving on either side before the run
  // is declared hung. The longest legal quiet stretch is the long receiver hold.
  localparam int QUIET_LIMIT   = 2000;
  // Length of the deliberate receiver hold used to back the block up.
  localparam int HOLD_CYCLES   = 64;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 140;

  // One finished pulse as it is expected on the peaks channel.
  typedef struct packed {
    logic [ppd_pkg::OUT_INDEX_BITS-1:0] index;
    logic [ppd_pkg::AMP_BITS-1:0]       amplitude;
    logic [ppd_pkg::COUNT_BITS-1:0]     count;
  } pulse_word_t;

  logic clk = 1'b0;
  logic rst;
  logic                         cfg_we;
  logic                         cfg_index;
  logic [ppd_pkg::CFG_BITS-1:0] cfg_data;

  ppd_sample_if samples_if ();
  ppd_peak_if   peaks_if ();

  pulse_peak_detector dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .peaks     (peaks_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample words waiting to be offered, and finished pulses still owed by the block.
  logic [ppd_pkg::SAMPLE_BITS-1:0] sample_backlog [$];
  pulse_word_t                     pending_pulses [$];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  // The stimulus process raises hold_requests; the receiver serves each one
  // with a long hold that it counts down itself.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  // Shadow of the tracker: configuration and pulse state, updated once per
  // accepted sample word.
  logic [ppd_pkg::CFG_BITS-1:0]   cfg_threshold = ppd_pkg::THRESHOLD_RESET;
  logic [ppd_pkg::CFG_BITS-1:0]   cfg_holdoff   = ppd_pkg::HOLDOFF_RESET;
  ppd_pkg::phase_t                trk_phase     = ppd_pkg::PH_NOISE;
  logic [ppd_pkg::INDEX_BITS-1:0] trk_index     = '0;
  logic [ppd_pkg::INDEX_BITS-1:0] trk_peak_at   = '0;
  logic [ppd_pkg::AMP_BITS-1:0]   trk_peak_amp  = '0;
  logic [ppd_pkg::INDEX_BITS-1:0] trk_below_at  = '0;
  logic [ppd_pkg::COUNT_BITS-1:0] trk_pulses    = '0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Advance the shadow tracker by one sample and queue the pulse it closes, if any.
  task automatic track_sample(input logic [ppd_pkg::SAMPLE_BITS-1:0] s);
    logic [ppd_pkg::AMP_BITS-1:0]   mag;
    logic                           above;
    logic                           opened;
    logic [ppd_pkg::INDEX_BITS-1:0] gap;
    pulse_word_t                    w;
    // The most negative sample negates to itself, which reads as 32768 unsigned.
    mag    = s[ppd_pkg::SAMPLE_BITS-1] ? (~s + 1'b1) : s;
    above  = (mag >= cfg_threshold);
    opened = 1'b0;
    gap    = trk_index - trk_below_at;
    case (trk_phase)
      ppd_pkg::PH_LEAVING: begin
        if (above) begin
          trk_phase = ppd_pkg::PH_PEAK;
        end else if (gap > ppd_pkg::INDEX_BITS'(cfg_holdoff)) begin
          trk_pulses = trk_pulses + 1'b1;
          w.index     = trk_peak_at;
          w.amplitude = trk_peak_amp;
          w.count     = trk_pulses;
          pending_pulses.push_back(w);
          trk_phase = ppd_pkg::PH_NOISE;
        end
      end
      ppd_pkg::PH_PEAK: begin
      end
      default: begin
        trk_phase = ppd_pkg::PH_NOISE;
        if (above) begin
          trk_peak_at  = trk_index;
          trk_peak_amp = mag;
          trk_phase    = ppd_pkg::PH_PEAK;
          opened       = 1'b1;
        end
      end
    endcase
    // A return from leaving is handled as a peak sample on the same step.
    if (trk_phase == ppd_pkg::PH_PEAK && !opened) begin
      if (above) begin
        if (mag > trk_peak_amp) begin
          trk_peak_at  = trk_index;
          trk_peak_amp = mag;
        end
      end else begin
        trk_below_at = trk_index;
        trk_phase    = ppd_pkg::PH_LEAVING;
      end
    end
    trk_index = trk_index + 1'b1;
  endtask

  // Sender: offers the backlog one word at a time, idling at the current rate.
  // A word is accepted, and fed to the shadow tracker, at an edge where valid
  // and ready are both high.
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        track_sample(samples_if.sample);
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          samples_if.valid  <= 1'b1;
          samples_if.sample <= sample_backlog.pop_front();
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each accepted pulse word with the oldest expectation,
  // then decides ready for the next cycle. A pending hold request overrides
  // the random idling and keeps ready low until the hold has been counted down.
  always @(posedge clk) begin
    if (rst) begin
      peaks_if.ready <= 1'b0;
    end else begin
      if (peaks_if.valid && peaks_if.ready) begin
        if (pending_pulses.size() == 0) begin
          flag_mismatch("unexpected pulse, count", peaks_if.pulse_count, 32'd0);
        end else begin
          pulse_word_t w;
          w = pending_pulses.pop_front();
          if (peaks_if.peak_index !== w.index)
            flag_mismatch("peak_index", peaks_if.peak_index, w.index);
          if (peaks_if.peak_amplitude !== w.amplitude)
            flag_mismatch("peak_amplitude", 32'(peaks_if.peak_amplitude),
                          32'(w.amplitude));
          if (peaks_if.pulse_count !== w.count)
            flag_mismatch("pulse_count", peaks_if.pulse_count, w.count);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        peaks_if.ready <= 1'b0;
      end else if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        peaks_if.ready <= 1'b0;
      end else begin
        peaks_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any word moving on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (peaks_if.valid && peaks_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle mode 0: busy sender, choked receiver. Mode 1: the reverse. Other: no idling.
  task automatic use_idle_mode(input int mode);
    case (mode)
      0:       begin send_idle_pct = 19; recv_idle_pct = 84; end
      1:       begin send_idle_pct = 84; recv_idle_pct = 19; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  task automatic queue_sample(input logic [ppd_pkg::SAMPLE_BITS-1:0] s);
    sample_backlog.push_back(s);
  endtask

  // Build a sample word of the given magnitude; 32768 always comes out negative.
  function automatic logic [ppd_pkg::SAMPLE_BITS-1:0] signed_word(input int mag,
                                                                  input bit neg);
    logic [ppd_pkg::SAMPLE_BITS-1:0] m;
    m = mag[ppd_pkg::SAMPLE_BITS-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

  // A sample at or above the current threshold, or below it when none can be.
  function automatic logic [ppd_pkg::SAMPLE_BITS-1:0] loud_sample();
    int thr;
    thr = int'(cfg_threshold);
    if (thr > 32768)
      return signed_word(int'($urandom_range(32768)), 1'($urandom_range(1)));
    return signed_word(int'($urandom_range(32768, thr)), 1'($urandom_range(1)));
  endfunction

  // A sample below the current threshold; with a zero threshold nothing is below.
  function automatic logic [ppd_pkg::SAMPLE_BITS-1:0] quiet_sample();
    int top;
    top = int'(cfg_threshold) - 1;
    if (top < 0)
      return signed_word(int'($urandom_range(32768)), 1'($urandom_range(1)));
    if (top > 32768)
      top = 32768;
    return signed_word(int'($urandom_range(top)), 1'($urandom_range(1)));
  endfunction

  // Mostly whole pulses: a loud stretch with short dips, then a quiet tail
  // that lands near the holdoff so some pulses end and some are re-entered.
  // The rest is full-range noise.
  task automatic queue_random_phase(input int n_items);
    int made;
    int len;
    int k;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(99) < 20) begin
        queue_sample(ppd_pkg::SAMPLE_BITS'($urandom()));
        made++;
      end else begin
        len = int'($urandom_range(6, 1));
        for (k = 0; k < len; k++) begin
          if ($urandom_range(3) == 0) queue_sample(quiet_sample());
          else queue_sample(loud_sample());
        end
        made += len;
        len = int'(cfg_holdoff) + int'($urandom_range(3));
        for (k = 0; k < len; k++) begin
          queue_sample(quiet_sample());
        end
        made += len;
      end
    end
  endtask

  // Returns once every word is accepted, every pulse has arrived and the
  // pipeline has had time to empty, so the block is idle.
  task automatic wait_until_drained();
    @(negedge clk);
    while (sample_backlog.size() != 0 || samples_if.valid || pending_pulses.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ppd_pkg::CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ppd_pkg::CFG_THRESHOLD) cfg_threshold = val;
    else cfg_holdoff = val;
    @(negedge clk);
  endtask

  // Stimulus: directed pulses under the reset settings, the threshold and
  // holdoff extremes, the longest holdoff, a backed-up output, then random phases.
  initial begin
    int p;
    int k;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = ppd_pkg::CFG_THRESHOLD;
    cfg_data          = '0;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    peaks_if.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, threshold 1000 and holdoff 4. The first pulse starts
    // exactly at threshold, peaks at the most negative sample and keeps the
    // earlier index on a tie; the second drops out and comes back before its
    // holdoff runs out.
    use_idle_mode(0);
    queue_sample(16'd0);      queue_sample(16'd999);    queue_sample(16'd1000);
    queue_sample(16'd32767);  queue_sample(16'h8000);   queue_sample(16'h8000);
    queue_sample(16'd5);
    for (k = 0; k < 5; k++) queue_sample(16'd0);
    queue_sample(16'd2000);   queue_sample(16'd0);      queue_sample(16'd0);
    queue_sample(16'd3000);   queue_sample(-16'sd1000); queue_sample(-16'sd999);
    for (k = 0; k < 5; k++) queue_sample(16'd0);
    wait_until_drained();

    // Zero threshold: every sample is part of the pulse, so it never ends.
    write_reg(ppd_pkg::CFG_THRESHOLD, 16'd0);
    write_reg(ppd_pkg::CFG_HOLDOFF, 16'd0);
    use_idle_mode(1);
    queue_sample(16'd0); queue_sample(16'd1); queue_sample(-16'sd1);
    queue_sample(16'd0); queue_sample(16'd32767);
    wait_until_drained();

    // Threshold 32768: only the most negative sample counts as loud.
    write_reg(ppd_pkg::CFG_THRESHOLD, 16'h8000);
    queue_sample(16'd32767);  queue_sample(16'h8000);   queue_sample(16'h8000);
    queue_sample(16'd32767);  queue_sample(16'd0);      queue_sample(16'd0);
    wait_until_drained();

    // Threshold beyond any magnitude: no pulse can start.
    write_reg(ppd_pkg::CFG_THRESHOLD, 16'hFFFF);
    write_reg(ppd_pkg::CFG_HOLDOFF, 16'd3);
    for (k = 0; k < 8; k++) queue_sample(ppd_pkg::SAMPLE_BITS'($urandom()));
    wait_until_drained();

    // Largest holdoff: a long quiet stretch leaves the pulse open; it is
    // closed later, once the holdoff drops back to zero.
    write_reg(ppd_pkg::CFG_THRESHOLD, 16'd1000);
    write_reg(ppd_pkg::CFG_HOLDOFF, 16'hFFFF);
    use_idle_mode(2);
    queue_sample(16'd20000);
    for (k = 0; k < 40; k++) queue_sample(16'd0);
    wait_until_drained();

    // Back-to-back pulses every three samples while the receiver holds off,
    // so both internal registers fill and the input stalls.
    write_reg(ppd_pkg::CFG_HOLDOFF, 16'd0);
    hold_requests++;
    for (k = 0; k < 32; k++) begin
      queue_sample(loud_sample());
      queue_sample(quiet_sample());
      queue_sample(quiet_sample());
    end
    wait_until_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 5)
        0: write_reg(ppd_pkg::CFG_THRESHOLD,
                     ppd_pkg::CFG_BITS'($urandom_range(3000, 200)));
        1: write_reg(ppd_pkg::CFG_THRESHOLD,
                     ppd_pkg::CFG_BITS'($urandom_range(32768, 20000)));
        2: write_reg(ppd_pkg::CFG_THRESHOLD,
                     ppd_pkg::CFG_BITS'($urandom_range(65535)));
        3: write_reg(ppd_pkg::CFG_THRESHOLD,
                     ppd_pkg::CFG_BITS'($urandom_range(1000, 1)));
        default: write_reg(ppd_pkg::CFG_THRESHOLD,
                           ppd_pkg::CFG_BITS'($urandom_range(600, 100)));
      endcase
      if ($urandom_range(3) == 0)
        write_reg(ppd_pkg::CFG_HOLDOFF, ppd_pkg::CFG_BITS'($urandom_range(40)));
      else
        write_reg(ppd_pkg::CFG_HOLDOFF, ppd_pkg::CFG_BITS'($urandom_range(6)));
      use_idle_mode(p % 3);
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
